/* rtl/core/bkes_pkg.sv */
package bkes_pkg;

  localparam int MAX_KEY_BYTES = 64;
  localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KEY_LW = $clog2(MAX_KEY_BYTES + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;
  localparam int FIFO_CW = 3;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_BLOCK  = 2'd1,
    OP_FINISH = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_VALUE    = 3'd0,
    KIND_FOUND    = 3'd1,
    KIND_TOMB     = 3'd2,
    KIND_NOTFOUND = 3'd3,
    KIND_CORRUPT  = 3'd4,
    KIND_UNKNOWN  = 3'd5,
    KIND_BADKEY   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    PH_KEY_LEN = 3'd0,
    PH_KEY     = 3'd1,
    PH_TAG     = 3'd2,
    PH_VAL_LEN = 3'd3,
    PH_VALUE   = 3'd4
  } phase_t;

  localparam logic CFG_DATA_TAG = 1'b0;
  localparam logic CFG_TOMB_TAG = 1'b1;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       done_res;
  } result_t;

endpackage

/* rtl/core/bkes_if.sv */
interface bkes_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output op, output data_byte, output last, input ready);
  modport sink (input valid, input op, input data_byte, input last, output ready);
endinterface

interface bkes_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic       done_res;

  modport source (output valid, output kind, output out_byte, output done_res, input ready);
  modport sink (input valid, input kind, input out_byte, input done_res, output ready);
endinterface

/* rtl/core/block_entry_key_scanner.sv */
// Looks up one search key in a stream of uncompressed table blocks.
// in_ch carries beats of {op, data_byte, last}: search key bytes first, then
// block payload bytes, then a finish beat. out_ch carries result beats of
// {kind, out_byte, done_res}: streamed value bytes of the matching entry and
// one final result per lookup. cfg_we/cfg_index/cfg_wdata set the data and
// tombstone tag codes; write them only while the block is idle.
// Throughput: one input beat per cycle while in_ch.ready is high. A beat
// that yields two results (value byte plus decision) queues both, and
// out_ch drains them one after the other from the registered queue.
// The search key sits in a 64 x 8 synchronous RAM; a key byte compare is
// read in the cycle of the beat and resolved in the next cycle, forwarded
// into the match flag.
// A 4-entry result queue decouples the sides: in_ch.ready drops once fewer
// than two slots are free, so a stalled receiver back-pressures the input.
// Synchronous reset (rst_n low) resets the parse state, key status, tag codes
// and queue; the key RAM is not cleared and needs no clearing pass.
module block_entry_key_scanner (
  input  logic                 clk,
  input  logic                 rst_n,
  bkes_in_if.sink              in_ch,
  bkes_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_wdata
);

  logic [7:0] key_mem [bkes_pkg::MAX_KEY_BYTES];
  logic [7:0] mem_q_r;

  logic [7:0] data_tag_r;
  logic [7:0] tomb_tag_r;

  logic [bkes_pkg::KEY_LW-1:0] sk_len_r, sk_len_nxt;
  logic key_ready_r, key_ready_nxt;
  logic key_open_r, key_open_nxt;
  logic key_ovf_r, key_ovf_nxt;
  bkes_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] fc_r, fc_nxt;
  logic [31:0] ekl_r, ekl_nxt;
  logic [31:0] evl_r, evl_nxt;
  logic ke_r, ke_nxt;
  logic [7:0] tag_r, tag_nxt;
  logic dec_r, dec_nxt;

  logic cmp_pend_r, cmp_pend_nxt;
  logic cmp_oob_r, cmp_oob_nxt;
  logic [7:0] cmp_byte_r, cmp_byte_nxt;

  logic mem_we;
  logic [bkes_pkg::KEY_AW-1:0] mem_waddr;
  logic mem_re;
  logic [bkes_pkg::KEY_AW-1:0] mem_raddr;

  bkes_pkg::result_t res0, res1;
  logic push0, push1;

  bkes_pkg::result_t fifo_r [bkes_pkg::FIFO_DEPTH];
  logic [bkes_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [bkes_pkg::FIFO_CW-1:0] cnt_r;
  logic accept;
  logic pop;
  logic ke_cur;

  assign in_ch.ready = (cnt_r <= bkes_pkg::FIFO_CW'(bkes_pkg::FIFO_DEPTH - 2));
  assign accept = in_ch.valid && in_ch.ready;
  assign pop = out_ch.valid && out_ch.ready;
  assign ke_cur = ke_r && !(cmp_pend_r && (cmp_oob_r || (mem_q_r != cmp_byte_r)));

  always_comb begin
    bkes_pkg::phase_t ph;
    logic [31:0] fc;
    logic [31:0] ekl;
    logic [31:0] evl;
    logic ke;
    logic [7:0] tag;
    logic dec;
    logic [31:0] fc_inc;
    logic [31:0] shifted;
    logic end_ent;
    bkes_pkg::kind_t dk;

    ph = phase_r;
    fc = fc_r;
    ekl = ekl_r;
    evl = evl_r;
    ke = ke_cur;
    tag = tag_r;
    dec = dec_r;
    fc_inc = fc_r + 32'd1;
    shifted = 32'(in_ch.data_byte) << {fc_r[1:0], 3'b000};
    end_ent = 1'b0;
    dk = bkes_pkg::KIND_UNKNOWN;

    sk_len_nxt = sk_len_r;
    key_ready_nxt = key_ready_r;
    key_open_nxt = key_open_r;
    key_ovf_nxt = key_ovf_r;
    cmp_pend_nxt = 1'b0;
    cmp_oob_nxt = cmp_oob_r;
    cmp_byte_nxt = cmp_byte_r;
    mem_we = 1'b0;
    mem_waddr = sk_len_r[bkes_pkg::KEY_AW-1:0];
    mem_re = 1'b0;
    mem_raddr = fc_r[bkes_pkg::KEY_AW-1:0];
    push0 = 1'b0;
    push1 = 1'b0;
    res0 = '{kind: bkes_pkg::KIND_VALUE, out_byte: 8'd0, done_res: 1'b0};
    res1 = '{kind: bkes_pkg::KIND_VALUE, out_byte: 8'd0, done_res: 1'b0};

    if (accept) begin
      case (bkes_pkg::op_t'(in_ch.op))
        bkes_pkg::OP_KEY: begin
          if (!key_open_r) begin
            key_open_nxt = 1'b1;
            key_ready_nxt = 1'b0;
            key_ovf_nxt = 1'b0;
            sk_len_nxt = '0;
            ph = bkes_pkg::PH_KEY_LEN;
            fc = '0;
            ekl = '0;
            evl = '0;
            ke = 1'b1;
            tag = '0;
            dec = 1'b0;
          end
          if (key_open_r
              && sk_len_r >= bkes_pkg::KEY_LW'(bkes_pkg::MAX_KEY_BYTES)) begin
            key_ovf_nxt = 1'b1;
          end else begin
            mem_we = 1'b1;
            mem_waddr = key_open_r ? sk_len_r[bkes_pkg::KEY_AW-1:0] : '0;
            sk_len_nxt = (key_open_r ? sk_len_r : '0) + bkes_pkg::KEY_LW'(1);
          end
          if (in_ch.last) begin
            key_open_nxt = 1'b0;
            if (key_ovf_nxt) begin
              push0 = 1'b1;
              res0.kind = bkes_pkg::KIND_BADKEY;
              res0.done_res = 1'b1;
              sk_len_nxt = '0;
              key_ovf_nxt = 1'b0;
            end else begin
              key_ready_nxt = 1'b1;
            end
          end
        end
        bkes_pkg::OP_BLOCK: begin
          if (key_ready_r && !dec_r) begin
            case (phase_r)
              bkes_pkg::PH_KEY_LEN: begin
                ekl = ekl_r | shifted;
                fc = fc_inc;
                if (fc_inc == 32'd4) begin
                  fc = '0;
                  ke = (ekl == 32'(sk_len_r));
                  ph = (ekl != 32'd0) ? bkes_pkg::PH_KEY : bkes_pkg::PH_TAG;
                end
              end
              bkes_pkg::PH_KEY: begin
                mem_re = 1'b1;
                cmp_pend_nxt = 1'b1;
                cmp_oob_nxt = (fc_r >= 32'(sk_len_r));
                cmp_byte_nxt = in_ch.data_byte;
                fc = fc_inc;
                if (fc_inc == ekl_r) begin
                  fc = '0;
                  ph = bkes_pkg::PH_TAG;
                end
              end
              bkes_pkg::PH_TAG: begin
                tag = in_ch.data_byte;
                evl = '0;
                fc = '0;
                ph = bkes_pkg::PH_VAL_LEN;
              end
              bkes_pkg::PH_VAL_LEN: begin
                evl = evl_r | shifted;
                fc = fc_inc;
                if (fc_inc == 32'd4) begin
                  fc = '0;
                  if (evl == 32'd0) end_ent = 1'b1;
                  else ph = bkes_pkg::PH_VALUE;
                end
              end
              default: begin
                if (ke_cur && tag_r == data_tag_r && tag_r != tomb_tag_r) begin
                  push0 = 1'b1;
                  res0.kind = bkes_pkg::KIND_VALUE;
                  res0.out_byte = in_ch.data_byte;
                end
                fc = fc_inc;
                if (fc_inc == evl_r) end_ent = 1'b1;
              end
            endcase
            if (end_ent) begin
              if (ke) begin
                if (tag == tomb_tag_r) dk = bkes_pkg::KIND_TOMB;
                else if (tag == data_tag_r) dk = bkes_pkg::KIND_FOUND;
                else dk = bkes_pkg::KIND_UNKNOWN;
                if (push0) begin
                  push1 = 1'b1;
                  res1.kind = dk;
                  res1.done_res = 1'b1;
                end else begin
                  push0 = 1'b1;
                  res0.kind = dk;
                  res0.done_res = 1'b1;
                end
                dec = 1'b1;
              end
              ph = bkes_pkg::PH_KEY_LEN;
              fc = '0;
              ekl = '0;
              evl = '0;
              ke = 1'b1;
              tag = '0;
              cmp_pend_nxt = 1'b0;
            end
            if (in_ch.last) begin
              if (!dec && (ph != bkes_pkg::PH_KEY_LEN || fc != 32'd0)) begin
                if (push0) begin
                  push1 = 1'b1;
                  res1.kind = bkes_pkg::KIND_CORRUPT;
                  res1.done_res = 1'b1;
                end else begin
                  push0 = 1'b1;
                  res0.kind = bkes_pkg::KIND_CORRUPT;
                  res0.done_res = 1'b1;
                end
                dec = 1'b1;
              end
              ph = bkes_pkg::PH_KEY_LEN;
              fc = '0;
              ekl = '0;
              evl = '0;
              ke = 1'b1;
              tag = '0;
              cmp_pend_nxt = 1'b0;
            end
          end
        end
        bkes_pkg::OP_FINISH: begin
          if (!key_ready_r) begin
            push0 = 1'b1;
            res0.kind = bkes_pkg::KIND_BADKEY;
            res0.done_res = 1'b1;
            key_open_nxt = 1'b0;
            key_ovf_nxt = 1'b0;
            sk_len_nxt = '0;
          end else if (!dec_r) begin
            push0 = 1'b1;
            res0.done_res = 1'b1;
            if (phase_r != bkes_pkg::PH_KEY_LEN || fc_r != 32'd0)
              res0.kind = bkes_pkg::KIND_CORRUPT;
            else
              res0.kind = bkes_pkg::KIND_NOTFOUND;
          end
          ph = bkes_pkg::PH_KEY_LEN;
          fc = '0;
          ekl = '0;
          evl = '0;
          ke = 1'b1;
          tag = '0;
          dec = 1'b0;
        end
        default: begin
        end
      endcase
    end

    phase_nxt = ph;
    fc_nxt = fc;
    ekl_nxt = ekl;
    evl_nxt = evl;
    ke_nxt = ke;
    tag_nxt = tag;
    dec_nxt = dec;
  end

  always_ff @(posedge clk) begin
    if (mem_we) key_mem[mem_waddr] <= in_ch.data_byte;
    if (mem_re) mem_q_r <= key_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_tag_r <= 8'd0;
      tomb_tag_r <= 8'd1;
    end else if (cfg_we) begin
      if (cfg_index == bkes_pkg::CFG_DATA_TAG) data_tag_r <= cfg_wdata;
      else tomb_tag_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_len_r <= '0;
      key_ready_r <= 1'b0;
      key_open_r <= 1'b0;
      key_ovf_r <= 1'b0;
      phase_r <= bkes_pkg::PH_KEY_LEN;
      fc_r <= '0;
      ekl_r <= '0;
      evl_r <= '0;
      ke_r <= 1'b1;
      tag_r <= '0;
      dec_r <= 1'b0;
      cmp_pend_r <= 1'b0;
    end else begin
      sk_len_r <= sk_len_nxt;
      key_ready_r <= key_ready_nxt;
      key_open_r <= key_open_nxt;
      key_ovf_r <= key_ovf_nxt;
      phase_r <= phase_nxt;
      fc_r <= fc_nxt;
      ekl_r <= ekl_nxt;
      evl_r <= evl_nxt;
      ke_r <= ke_nxt;
      tag_r <= tag_nxt;
      dec_r <= dec_nxt;
      cmp_pend_r <= cmp_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_oob_r <= cmp_oob_nxt;
    cmp_byte_r <= cmp_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (push0) fifo_r[wr_ptr_r] <= res0;
    if (push1) fifo_r[wr_ptr_r + bkes_pkg::FIFO_AW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + bkes_pkg::FIFO_AW'(push0) + bkes_pkg::FIFO_AW'(push1);
      if (pop) rd_ptr_r <= rd_ptr_r + bkes_pkg::FIFO_AW'(1);
      cnt_r <= cnt_r + bkes_pkg::FIFO_CW'(push0) + bkes_pkg::FIFO_CW'(push1)
               - bkes_pkg::FIFO_CW'(pop);
    end
  end

  assign out_ch.valid = (cnt_r != '0);
  assign out_ch.kind = fifo_r[rd_ptr_r].kind;
  assign out_ch.out_byte = fifo_r[rd_ptr_r].out_byte;
  assign out_ch.done_res = fifo_r[rd_ptr_r].done_res;

endmodule
